@@ rtl/sgb_pkg.sv @@
// Package of shared constants, types and codes for the separable Gaussian blur core.
`default_nettype none
package sgb_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 7;
    localparam int NTAPS      = 2 * MAX_RADIUS + 1;
    localparam int SLOTS      = 2 * MAX_RADIUS;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int TAP_W      = $clog2(NTAPS);
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    localparam int ADDR_W     = SLOT_W + COL_W;
    localparam int DEPTH      = SLOTS * MAX_WIDTH;
    localparam int HS_W       = 28;
    localparam int TV_W       = 16;
    localparam int VACC_W     = HS_W + TV_W + TAP_W;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 12;
    localparam int RADF_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TAP   = 1'b1;

    typedef enum logic [1:0] {ST_IDLE, ST_HSUM, ST_VSUM, ST_FIN} t_state;
endpackage
`default_nettype wire

@@ rtl/sgb_if.sv @@
// Stream interfaces for the input words and the result words of the blur core.
`default_nettype none
interface sgb_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;
    logic [3:0]  tap_index;
    logic [15:0] tap_value;
    modport source (output valid, kind, red_in, green_in, blue_in, alpha_in,
                    tap_index, tap_value, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, alpha_in,
                    tap_index, tap_value, output ready);
endinterface

interface sgb_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  out_x;
    logic [11:0] out_y;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        frame_end;
    modport source (output valid, out_x, out_y, red_out, green_out, blue_out,
                    alpha_out, frame_end, input ready);
    modport sink   (input valid, out_x, out_y, red_out, green_out, blue_out,
                    alpha_out, frame_end, output ready);
endinterface
`default_nettype wire

@@ rtl/separable_gaussian_blur_core.sv @@
// Top level of the streaming separable Gaussian blur core for RGBA pixels.
`default_nettype none
// The core takes raster-order RGBA pixel words and tap-load words on one
// input channel and returns blurred interior pixels on the output channel.
// A tap word, or a pixel word whose column is below 2*radius, is only
// accepted. Any other pixel word is accepted, then runs the horizontal
// multiply-accumulate (one tap per cycle through three 8x16 multipliers),
// then, for rows at or past 2*radius, the vertical pass (one row-store read
// per tap through the single read port of the row-store memory, followed by
// a registered 28x16 multiply and accumulate, until the emptied pipeline is
// seen), and a final step that writes the horizontal sums back and hands
// over any result. The result sits in an output register, so the next word
// is accepted while it waits; only the final step of a following pixel with
// a result stalls, while that register is full and not taken. Row stores
// are one 84-bit wide memory of 2*MAX_RADIUS rows by MAX_WIDTH columns plus
// an alpha memory of the same shape; neither needs a clearing pass.
// Configuration writes are taken at any cycle but should only be made while
// the core is idle; taps should be loaded between frames.
module separable_gaussian_blur_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [sgb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [sgb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    sgb_in_if.sink                             i_in,
    sgb_out_if.source                          o_out
);
    import sgb_pkg::*;

    // Configuration registers.
    logic [WID_W-1:0]  r_width;
    logic [HGT_W-1:0]  r_height;
    logic [RADF_W-1:0] r_radius;

    // Frame position counters and the row-store slot of the current row.
    logic [COL_W-1:0]  r_col;
    logic [HGT_W-1:0]  r_row;
    logic [SLOT_W-1:0] r_row_slot;

    t_state r_state, n_state;

    // Kernel taps and the horizontal pixel window (newest pixel at index 0).
    logic [TV_W-1:0] r_taps [NTAPS];
    logic [23:0]     r_win  [NTAPS];

    // Position of the word in flight.
    logic [COL_W-1:0]  r_x;
    logic [HGT_W-1:0]  r_y;
    logic [SLOT_W-1:0] r_slot;
    logic [RAD_W-1:0]  r_r;
    logic              r_emit;
    logic              r_last;

    // Horizontal and vertical accumulators, one per color channel.
    logic [HS_W-1:0]   r_hacc [3];
    logic [VACC_W-1:0] r_vacc [3];
    logic [HS_W+TV_W-1:0] r_prod [3];

    // Sequencing counters and the vertical pipeline flags.
    logic [TAP_W-1:0] r_t;
    logic [TAP_W-1:0] r_ti;
    logic             r_iss;
    logic             r_v1;
    logic [TAP_W-1:0] r_t1;
    logic             r_d01;
    logic             r_v2;

    // Row-store memories.
    logic [3*HS_W-1:0] r_hmem [DEPTH];
    logic [7:0]        r_amem [DEPTH];
    logic [3*HS_W-1:0] r_hrd;
    logic [7:0]        r_ard;

    // Output register.
    logic        r_out_valid;
    logic [9:0]  r_out_x;
    logic [11:0] r_out_y;
    logic [7:0]  r_out_c [3];
    logic [7:0]  r_out_a;
    logic        r_out_last;

    // Effective sizes.
    logic [CNT_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [RAD_W-1:0]  r_eff;
    logic [TAP_W-1:0]  two_r;
    logic [TAP_W-1:0]  two_rr;

    always_comb begin
        if (r_width == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(r_width);
        end
        h_eff = (r_height == '0) ? HGT_W'(1) : r_height;
        r_eff = (32'(r_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_radius);
        two_r  = TAP_W'({r_eff, 1'b0});
        two_rr = TAP_W'({r_r, 1'b0});
    end

    // Position of an arriving pixel, with counters wrapped if a size shrank.
    logic [COL_W-1:0]  x0;
    logic [HGT_W-1:0]  y0;
    logic [SLOT_W-1:0] s0;
    logic [CNT_W-1:0]  x_inc;
    logic [HGT_W:0]    y_inc;
    logic              hstart;
    logic              emit0;
    logic              last0;
    logic [COL_W-1:0]  n_col;
    logic [HGT_W-1:0]  n_row;
    logic [SLOT_W-1:0] n_row_slot;

    always_comb begin
        x0 = (CNT_W'(r_col) >= w_eff) ? '0 : r_col;
        y0 = (r_row >= h_eff) ? '0 : r_row;
        s0 = (r_row >= h_eff) ? '0 : r_row_slot;
        x_inc = CNT_W'(x0) + CNT_W'(1);
        y_inc = {1'b0, y0} + (HGT_W+1)'(1);
        hstart = CNT_W'(x0) >= CNT_W'(two_r);
        emit0  = y0 >= HGT_W'(two_r);
        last0  = (x_inc == w_eff) && (y_inc == {1'b0, h_eff});
        n_col = r_col;
        n_row = r_row;
        n_row_slot = r_row_slot;
        if (x_inc >= w_eff) begin
            n_col = '0;
            if (y_inc >= {1'b0, h_eff}) begin
                n_row = '0;
                n_row_slot = '0;
            end else begin
                n_row = y_inc[HGT_W-1:0];
                n_row_slot = (s0 == SLOT_W'(SLOTS - 1)) ? '0 : s0 + SLOT_W'(1);
            end
        end else begin
            n_col = x_inc[COL_W-1:0];
        end
    end

    logic acc_in;
    logic acc_pix;
    logic acc_tap;
    assign i_in.ready = (r_state == ST_IDLE);
    assign acc_in  = i_in.valid && i_in.ready;
    assign acc_pix = acc_in && (i_in.kind == KIND_PIXEL);
    assign acc_tap = acc_in && (i_in.kind == KIND_TAP);

    // Center column and row-store addressing.
    logic [COL_W-1:0]  cx;
    logic [TAP_W-1:0]  d_iss;
    logic [SLOT_W:0]   rs_tmp;
    logic [SLOT_W-1:0] rs_slot;
    logic [SLOT_W:0]   as_tmp;
    logic [SLOT_W-1:0] as_slot;
    logic [ADDR_W-1:0] h_raddr;
    logic [ADDR_W-1:0] a_raddr;

    always_comb begin
        cx = r_x - COL_W'(r_r);
        d_iss = two_rr - r_ti;
        rs_tmp = {1'b0, r_slot} + (SLOT_W+1)'(SLOTS) - (SLOT_W+1)'(d_iss);
        if (rs_tmp >= (SLOT_W+1)'(SLOTS)) begin
            rs_tmp = rs_tmp - (SLOT_W+1)'(SLOTS);
        end
        rs_slot = rs_tmp[SLOT_W-1:0];
        as_tmp = {1'b0, r_slot} + (SLOT_W+1)'(SLOTS) - (SLOT_W+1)'(r_r);
        if (as_tmp >= (SLOT_W+1)'(SLOTS)) begin
            as_tmp = as_tmp - (SLOT_W+1)'(SLOTS);
        end
        as_slot = as_tmp[SLOT_W-1:0];
        h_raddr = {rs_slot, cx};
        a_raddr = {as_slot, cx};
    end

    logic fin_go;
    assign fin_go = (r_state == ST_FIN) && (!r_emit || !r_out_valid || o_out.ready);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_pix && hstart) begin
                    n_state = ST_HSUM;
                end
            end
            ST_HSUM: begin
                if (r_t == two_rr) begin
                    n_state = r_emit ? ST_VSUM : ST_FIN;
                end
            end
            ST_VSUM: begin
                if (!r_iss && !r_v1 && !r_v2) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Configuration and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WID_W'(640);
            r_height   <= HGT_W'(480);
            r_radius   <= RADF_W'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_row_slot <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                    CFG_RADIUS: r_radius <= i_cfg_data[RADF_W-1:0];
                    default: ;
                endcase
            end
            if (acc_pix) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_row_slot <= n_row_slot;
            end
        end
    end

    // Taps, window and the latched position of the word in flight.
    always_ff @(posedge i_clk) begin
        if (acc_tap && (32'(i_in.tap_index) < NTAPS)) begin
            r_taps[TAP_W'(i_in.tap_index)] <= i_in.tap_value;
        end
        if (acc_pix) begin
            for (int n = NTAPS - 1; n > 0; n--) begin
                r_win[n] <= r_win[n-1];
            end
            r_win[0] <= {i_in.blue_in, i_in.green_in, i_in.red_in};
            r_x    <= x0;
            r_y    <= y0;
            r_slot <= s0;
            r_r    <= r_eff;
            r_emit <= emit0;
            r_last <= last0;
        end
    end

    // Horizontal pass: one tap per cycle, newest pixel weighted by the last tap.
    logic [TAP_W-1:0] win_idx;
    assign win_idx = two_rr - r_t;

    always_ff @(posedge i_clk) begin
        if (acc_pix) begin
            r_t <= '0;
            for (int c = 0; c < 3; c++) begin
                r_hacc[c] <= '0;
            end
        end else if (r_state == ST_HSUM) begin
            r_t <= r_t + TAP_W'(1);
            for (int c = 0; c < 3; c++) begin
                r_hacc[c] <= r_hacc[c] + HS_W'(r_win[win_idx][8*c +: 8] * r_taps[r_t]);
            end
        end
    end

    // Vertical pass: read, multiply and accumulate in three stages.
    logic [HS_W-1:0] v_op [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            v_op[c] = r_d01 ? r_hacc[c] : r_hrd[HS_W*c +: HS_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if ((r_state == ST_HSUM) && (r_t == two_rr) && r_emit) begin
                r_iss <= 1'b1;
            end else if (r_iss && (r_ti == two_rr)) begin
                r_iss <= 1'b0;
            end
            r_v1 <= r_iss;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_HSUM) && (r_t == two_rr)) begin
            r_ti <= '0;
            for (int c = 0; c < 3; c++) begin
                r_vacc[c] <= '0;
            end
        end else begin
            if (r_iss) begin
                r_ti <= r_ti + TAP_W'(1);
            end
            if (r_v2) begin
                for (int c = 0; c < 3; c++) begin
                    r_vacc[c] <= r_vacc[c] + VACC_W'(r_prod[c]);
                end
            end
        end
        r_t1  <= r_ti;
        r_d01 <= (d_iss == '0);
        for (int c = 0; c < 3; c++) begin
            r_prod[c] <= v_op[c] * r_taps[r_t1];
        end
    end

    // Row-store memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_hmem[{r_slot, cx}] <= {r_hacc[2], r_hacc[1], r_hacc[0]};
        end
        r_hrd <= r_hmem[h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_pix) begin
            r_amem[{s0, x0}] <= i_in.alpha_in;
        end
        r_ard <= r_amem[a_raddr];
    end

    // Truncate to the integer part and saturate each channel.
    logic [VACC_W-31:0] v_int [3];
    logic [7:0]         v_sat [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            v_int[c] = r_vacc[c][VACC_W-1:30];
            v_sat[c] = (v_int[c] > (VACC_W-30)'(255)) ? 8'd255 : v_int[c][7:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go && r_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go && r_emit) begin
            r_out_x    <= 10'(cx);
            r_out_y    <= r_y - HGT_W'(r_r);
            r_out_a    <= r_ard;
            r_out_last <= r_last;
            for (int c = 0; c < 3; c++) begin
                r_out_c[c] <= v_sat[c];
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_x     = r_out_x;
    assign o_out.out_y     = r_out_y;
    assign o_out.red_out   = r_out_c[0];
    assign o_out.green_out = r_out_c[1];
    assign o_out.blue_out  = r_out_c[2];
    assign o_out.alpha_out = r_out_a;
    assign o_out.frame_end = r_out_last;
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the separable Gaussian blur core.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgb_pkg::*;

    // One input word and one blurred output pixel, at the widths of the channels.
    typedef struct packed {
        logic        kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [3:0]  tap_index;
        logic [15:0] tap_value;
    } word_t;

    typedef struct packed {
        logic [9:0]  x;
        logic [11:0] y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        frame_end;
    } blur_px_t;

    typedef struct packed {
        word_t    w;
        logic     typed;
        blur_px_t px;
    } stim_row_t;

    // Settling wait for drain(), sized for the slowest pixel word plus a margin.
    localparam int LATENCY = 4 * MAX_RADIUS + 12;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sgb_in_if  in_ch();
    sgb_out_if out_ch();

    separable_gaussian_blur_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow copy of the core: registers, taps, pixel window, row stores and counters.
    logic [WID_W-1:0]  shadow_width;
    logic [HGT_W-1:0]  shadow_height;
    logic [RADF_W-1:0] shadow_radius;
    logic [15:0]       taps [0:NTAPS-1];
    logic [31:0]       pix_window [0:NTAPS-1];
    logic [27:0]       hsum_rows [0:2][0:DEPTH-1];
    logic [7:0]        alpha_store [0:DEPTH-1];
    int unsigned       col_cnt;
    int unsigned       row_cnt;

    blur_px_t pending_px[$];
    int       errors;
    int       mismatches;
    bit       calm;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("separable_gaussian_blur_core test failed");
        $finish;
    end

    // Advances the shadow copy by one accepted word; a pixel may yield one blurred pixel.
    task automatic blur_step(input word_t w, output bit got, output blur_px_t px);
        int unsigned       wd, ht, rd, x, y, slot, cx, d, n, c, t;
        int unsigned       hacc;
        longint unsigned   vacc, hv, v;
        logic [27:0]       hs [0:2];
        logic [7:0]        chan [0:2];
        wd = (shadow_width == 0) ? 1 : (shadow_width > MAX_WIDTH) ? MAX_WIDTH : shadow_width;
        ht = (shadow_height == 0) ? 1 : shadow_height;
        rd = shadow_radius;
        got = 1'b0;
        px = '0;
        if (w.kind == KIND_TAP) begin
            // Tap positions past the widest kernel are dropped.
            if (w.tap_index < NTAPS) taps[w.tap_index] = w.tap_value;
            return;
        end
        x = (col_cnt >= wd) ? 0 : col_cnt;
        y = (row_cnt >= ht) ? 0 : row_cnt;
        for (n = NTAPS - 1; n > 0; n--) pix_window[n] = pix_window[n-1];
        pix_window[0] = {w.alpha, w.blue, w.green, w.red};
        slot = y % SLOTS;
        alpha_store[slot * MAX_WIDTH + x] = w.alpha;
        if (x >= 2 * rd) begin
            cx = x - rd;
            for (c = 0; c < 3; c++) begin
                hacc = 0;
                for (t = 0; t <= 2 * rd; t++)
                    hacc += ((pix_window[2*rd-t] >> (8 * c)) & 8'hFF) * taps[t];
                hs[c] = hacc[27:0];
            end
            if (y >= 2 * rd) begin
                for (c = 0; c < 3; c++) begin
                    vacc = 0;
                    for (t = 0; t <= 2 * rd; t++) begin
                        d = 2 * rd - t;
                        hv = (d == 0) ? hs[c]
                                      : hsum_rows[c][((y + SLOTS - d) % SLOTS) * MAX_WIDTH + cx];
                        vacc += hv * taps[t];
                    end
                    v = vacc >> 30;
                    chan[c] = (v > 255) ? 8'hFF : v[7:0];
                end
                px.x = 10'(cx);
                px.y = 12'(y - rd);
                px.red = chan[0];
                px.green = chan[1];
                px.blue = chan[2];
                px.alpha = alpha_store[((y + SLOTS - rd) % SLOTS) * MAX_WIDTH + cx];
                px.frame_end = (x + 1 == wd && y + 1 == ht);
                got = 1'b1;
            end
            for (c = 0; c < 3; c++) hsum_rows[c][slot * MAX_WIDTH + cx] = hs[c];
        end
        x++;
        if (x >= wd) begin
            x = 0;
            y++;
            if (y >= ht) y = 0;
        end
        col_cnt = x;
        row_cnt = y;
    endtask

    // Presents one word from a falling edge and holds it until it is taken. A row
    // of the directed table may carry a hand-typed result that replaces the predicted one.
    task automatic send_word(input word_t w, input bit typed, input blur_px_t typed_px);
        bit       got;
        blur_px_t px;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 17) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= w.kind;
        in_ch.red_in    <= w.red;
        in_ch.green_in  <= w.green;
        in_ch.blue_in   <= w.blue;
        in_ch.alpha_in  <= w.alpha;
        in_ch.tap_index <= w.tap_index;
        in_ch.tap_value <= w.tap_value;
        do @(posedge i_clk); while (!in_ch.ready);
        blur_step(w, got, px);
        if (got) pending_px.push_back(typed ? typed_px : px);
    endtask

    task automatic send_pixel();
        word_t w;
        w = word_t'($bits(word_t)'({$urandom, $urandom}));
        w.kind = KIND_PIXEL;
        if ($urandom_range(9) == 0) w.red = 8'hFF;
        if ($urandom_range(9) == 0) w.green = 8'h00;
        send_word(w, 1'b0, '0);
    endtask

    // Loads the taps that the current radius uses: small weights that keep the
    // sums in range, the largest weight everywhere, or raw random words.
    task automatic load_taps(input int mode);
        word_t w;
        int    i;
        for (i = 0; i < 2 * shadow_radius + 1; i++) begin
            w = '0;
            w.kind = KIND_TAP;
            w.tap_index = 4'(i);
            w.tap_value = (mode == 1) ? 16'hFFFF : (mode == 2) ? 16'($urandom)
                        : 16'($urandom_range(0, 65536 / (2 * shadow_radius + 1)));
            send_word(w, 1'b0, '0);
        end
    endtask

    // Waits until every predicted pixel has come back, then lets the core settle.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_WIDTH:  shadow_width  = val[WID_W-1:0];
            CFG_HEIGHT: shadow_height = val[HGT_W-1:0];
            CFG_RADIUS: shadow_radius = val[RADF_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_frame(input int unsigned wd, input int unsigned ht, input int unsigned rd);
        cfg_write(CFG_WIDTH, wd);
        cfg_write(CFG_HEIGHT, ht);
        cfg_write(CFG_RADIUS, rd);
    endtask

    // Sends pixels, with random tap words mixed in if asked, until the shadow counters are back at the top left corner.
    task automatic finish_frame(input bit tap_noise);
        word_t w;
        do begin
            if (tap_noise && $urandom_range(99) < 3) begin
                w = word_t'($bits(word_t)'({$urandom, $urandom}));
                w.kind = KIND_TAP;
                send_word(w, 1'b0, '0);
            end
            send_pixel();
        end while (col_cnt != 0 || row_cnt != 0);
    endtask

    // Result side: stalls at random and checks every taken pixel against the oldest prediction.
    initial begin
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    always @(posedge i_clk) begin
        blur_px_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_px.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected pixel at x=%0d y=%0d", out_ch.out_x, out_ch.out_y);
            end else begin
                want = pending_px.pop_front();
                if (out_ch.out_x !== want.x || out_ch.out_y !== want.y ||
                    out_ch.red_out !== want.red || out_ch.green_out !== want.green ||
                    out_ch.blue_out !== want.blue || out_ch.alpha_out !== want.alpha ||
                    out_ch.frame_end !== want.frame_end) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("pixel mismatch: expected x=%0d y=%0d rgba=%h %h %h %h end=%b, got x=%0d y=%0d rgba=%h %h %h %h end=%b",
                                 want.x, want.y, want.red, want.green, want.blue, want.alpha,
                                 want.frame_end, out_ch.out_x, out_ch.out_y, out_ch.red_out,
                                 out_ch.green_out, out_ch.blue_out, out_ch.alpha_out,
                                 out_ch.frame_end);
                end
            end
        end
    end

    initial begin
        stim_row_t   table_rows [0:6];
        int          i, rd, wd, ht, phase;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        {in_ch.kind, in_ch.red_in, in_ch.green_in, in_ch.blue_in, in_ch.alpha_in,
         in_ch.tap_index, in_ch.tap_value} = '0;
        errors = 0;
        mismatches = 0;
        calm = 1'b0;
        shadow_width = 640;
        shadow_height = 480;
        shadow_radius = 1;
        col_cnt = 0;
        row_cnt = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed 2x2 frame with a one-tap kernel. A tap of exactly one passes the
        // pixel through unchanged; then the largest tap is loaded in mid-frame, and the
        // last pixel, weighted by it, closes the frame. Tap index 15 must be ignored.
        table_rows[0] = '{w: '{KIND_TAP, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 16'h8000},
                          typed: 1'b0, px: '0};
        table_rows[1] = '{w: '{KIND_TAP, 8'd0, 8'd0, 8'd0, 8'd0, 4'd15, 16'hFFFF},
                          typed: 1'b0, px: '0};
        table_rows[2] = '{w: '{KIND_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0, 16'd0},
                          typed: 1'b1, px: '{10'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}};
        table_rows[3] = '{w: '{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, 16'd0},
                          typed: 1'b1, px: '{10'd1, 12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}};
        table_rows[4] = '{w: '{KIND_PIXEL, 8'h55, 8'hAA, 8'h0F, 8'hF0, 4'd0, 16'd0},
                          typed: 1'b1, px: '{10'd0, 12'd1, 8'h55, 8'hAA, 8'h0F, 8'hF0, 1'b0}};
        table_rows[5] = '{w: '{KIND_TAP, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 16'hFFFF},
                          typed: 1'b0, px: '0};
        table_rows[6] = '{w: '{KIND_PIXEL, 8'h40, 8'h3F, 8'h00, 8'h80, 4'd0, 16'd0},
                          typed: 1'b0, px: '0};
        set_frame(2, 2, 0);
        for (i = 0; i < 7; i++) send_word(table_rows[i].w, table_rows[i].typed, table_rows[i].px);
        drain();

        // Narrow frame: width not above twice the radius, so nothing comes out.
        set_frame(3, 6, 2);
        load_taps(0);
        finish_frame(1'b0);
        drain();

        // Width shrinks in mid-frame while idle: the column counter wraps at the next pixel.
        set_frame(12, 8, 1);
        load_taps(0);
        for (i = 0; i < 3 * 12 + 9; i++) send_pixel();
        drain();
        cfg_write(CFG_WIDTH, 6);
        finish_frame(1'b0);
        drain();

        // Extremes: the widest row (2047 clamps to the maximum) and the tallest
        // column (width 0 counts as one) are run partway, the counters wrapping at
        // the next size change; then height 0 counting as one, and the largest
        // radius with the largest taps saturating.
        set_frame(2047, 1, 0);
        load_taps(2);
        for (i = 0; i < 24; i++) send_pixel();
        drain();
        set_frame(0, 4095, 0);
        for (i = 0; i < 24; i++) send_pixel();
        drain();
        set_frame(5, 0, 1);
        load_taps(0);
        finish_frame(1'b0);
        drain();
        set_frame(15, 15, 7);
        load_taps(1);
        finish_frame(1'b0);
        drain();

        // Random frames of small size; the middle phases run with no idling on either side.
        phase = 0;
        while (phase < 4) begin
            calm = (phase == 1 || phase == 2);
            rd = $urandom_range(0, 4);
            wd = ($urandom_range(4) == 0) ? $urandom_range(1, 2 * rd + 1)
                                          : $urandom_range(2 * rd + 1, 2 * rd + 4);
            ht = ($urandom_range(4) == 0) ? $urandom_range(1, 2 * rd + 1)
                                          : $urandom_range(2 * rd + 1, 2 * rd + 3);
            set_frame(wd, ht, rd);
            load_taps($urandom_range(3) == 0 ? 2 : 0);
            finish_frame(1'b1);
            drain();
            phase++;
        end
        calm = 1'b0;
        drain();

        if (pending_px.size() != 0) errors++;
        if (errors == 0)
            $display("separable_gaussian_blur_core test passed");
        else
            $display("separable_gaussian_blur_core test failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/sgb_pkg.sv
rtl/sgb_if.sv
rtl/separable_gaussian_blur_core.sv
verif/tb.sv
